>>> src/itl_pkg.sv
`default_nettype none
package itl_pkg;
   localparam int AltW = 32;
   localparam int ValW = 48;
   localparam int NumCols = 5;
   localparam int RatioW = 25;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [2:0] COL_DENSITY     = 3'd0;
   localparam logic [2:0] COL_PRESSURE    = 3'd1;
   localparam logic [2:0] COL_TEMPERATURE = 3'd2;
   localparam logic [2:0] COL_SOUND_SPEED = 3'd3;
   localparam logic [2:0] COL_WIND_SPEED  = 3'd4;

   typedef enum logic [1:0] {
      POS_INTERP = 2'd0,
      POS_FIRST  = 2'd1,
      POS_LAST   = 2'd2
   } pos_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_PRV_RD,
      ST_PRV_WAIT,
      ST_DIV,
      ST_VAL_RD,
      ST_VAL_WAIT,
      ST_MUL,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> src/itl_tables.sv
`default_nettype none
module itl_tables
   import itl_pkg::*;
#(
   parameter int Depth = 2048,
   parameter int AddrW = 11
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrW-1:0]     wr_addr,
   input  wire logic [AltW-1:0]      wr_alt,
   input  wire logic [ValW-1:0]      wr_q0,
   input  wire logic [ValW-1:0]      wr_q1,
   input  wire logic [ValW-1:0]      wr_q2,
   input  wire logic [ValW-1:0]      wr_q3,
   input  wire logic [ValW-1:0]      wr_q4,
   input  wire logic [AddrW-1:0]     rd_addr,
   input  wire logic [2:0]           rd_col,
   output logic      [AltW-1:0]      rd_alt,
   output logic      [ValW-1:0]      rd_val
);
   logic [AltW-1:0] alt_mem [Depth];
   logic [ValW-1:0] q0_mem [Depth];
   logic [ValW-1:0] q1_mem [Depth];
   logic [ValW-1:0] q2_mem [Depth];
   logic [ValW-1:0] q3_mem [Depth];
   logic [ValW-1:0] q4_mem [Depth];
   logic [ValW-1:0] q0_rd, q1_rd, q2_rd, q3_rd, q4_rd;
   logic [2:0]      col_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         alt_mem[wr_addr] <= wr_alt;
         q0_mem[wr_addr]  <= wr_q0;
         q1_mem[wr_addr]  <= wr_q1;
         q2_mem[wr_addr]  <= wr_q2;
         q3_mem[wr_addr]  <= wr_q3;
         q4_mem[wr_addr]  <= wr_q4;
      end
      rd_alt <= alt_mem[rd_addr];
      q0_rd  <= q0_mem[rd_addr];
      q1_rd  <= q1_mem[rd_addr];
      q2_rd  <= q2_mem[rd_addr];
      q3_rd  <= q3_mem[rd_addr];
      q4_rd  <= q4_mem[rd_addr];
      col_ff <= rd_col;
   end

   always_comb begin
      case (col_ff)
         COL_DENSITY: rd_val = q0_rd;
         COL_PRESSURE: rd_val = q1_rd;
         COL_TEMPERATURE: rd_val = q2_rd;
         COL_SOUND_SPEED: rd_val = q3_rd;
         default: rd_val = q4_rd;
      endcase
   end
endmodule
`default_nettype wire

>>> src/itl_div.sv
`default_nettype none
module itl_div
   import itl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [AltW:0]     num,
   input  wire logic [AltW:0]     den,
   output logic                   done,
   output logic [RatioW-1:0]      ratio
);
   // restoring division of num * 2^24 by den, one quotient bit per cycle
   logic [AltW+1:0]   rem_ff, rem_in;
   logic [RatioW-1:0] quo_ff, quo_in;
   logic [AltW:0]     den_ff, den_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in, done_in, done_ff;
   logic [AltW+1:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[AltW:0], 1'b0} - {1'b0, den_ff};
      if (start) begin
         rem_in = {1'b0, num};
         quo_in = '0;
         den_in = den;
         cnt_in = 5'd24;
         run_in = 1'b1;
         // first quotient bit: num >= den gives exactly one
         if (num >= den) begin
            quo_in = RatioW'(1) << 24;
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (run_ff) begin
         if (!trial[AltW+1]) begin
            rem_in = trial;
            quo_in = {quo_ff[RatioW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[AltW:0], 1'b0};
            quo_in = {quo_ff[RatioW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done  = done_ff;
   assign ratio = quo_ff;
endmodule
`default_nettype wire

>>> src/interpolating_table_lookup_top.sv
`default_nettype none
// interpolating table lookup
// a command is taken at a clock edge with start high and busy low.
// req_type 0 writes one table row (altitude and five quantities) at
// req_row_index and gives no response.
// req_type 1 queries req_altitude in the column req_quantity_select; the
// block does a lower-bound binary search over csr rows_in_use rows, with
// each probe a read of the synchronous altitude memory, then reads the
// neighbor rows, divides bit-serially and multiplies in two halves; at or
// below the first row or above the last it returns that row's value.
// its response shows for one cycle with rsp_valid high and must be taken
// then; the receiver cannot stall. one command is in flight at a time;
// busy stays high through the response cycle, so the next command is
// taken in the cycle after it at the earliest.
// csr_write_enable loads rows_in_use; write it only while busy is low.
// reset is synchronous: it returns the block to idle and rows_in_use to
// 2048; table contents are undefined until written.
module interpolating_table_lookup_top
   import itl_pkg::*;
#(
   parameter int TABLE_DEPTH = 2048
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_type,
   input  wire logic [10:0]          req_row_index,
   input  wire logic signed [31:0]   req_altitude,
   input  wire logic signed [47:0]   req_density,
   input  wire logic signed [47:0]   req_pressure,
   input  wire logic signed [47:0]   req_temperature,
   input  wire logic signed [47:0]   req_sound_speed,
   input  wire logic signed [47:0]   req_wind_speed,
   input  wire logic [2:0]           req_quantity_select,
   output logic                      rsp_valid,
   output logic signed [47:0]        rsp_value,
   output logic [1:0]                rsp_position,
   input  wire logic                 csr_write_enable,
   input  wire logic [11:0]          csr_write_data
);
   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = AddrW + 1;

   state_type state_ff, state_in;
   logic [11:0]      rows_ff;
   logic [CntW-1:0]  lo_ff, lo_in, hi_ff, hi_in, n_ff, n_in, mid;
   logic signed [AltW-1:0] q_ff, q_in, alt_i_ff, alt_i_in;
   logic [2:0]       col_ff, col_in;
   logic [ValW-1:0]  v1_ff, v1_in, val_ff, val_in;
   logic signed [ValW:0] diff_ff, diff_in;
   logic [RatioW-1:0] ratio_ff, ratio_in;
   logic signed [ValW+RatioW+1:0] prod_ff, prod_in;
   logic signed [RatioW:0] mul_a;
   logic signed [2*RatioW+1:0] mul_p;
   logic             sel_hi_ff, sel_hi_in;
   logic [1:0]       pos_ff, pos_in;
   logic             load_ff, load_in, rsp_ff, rsp_in;
   logic [AddrW-1:0] ld_addr_ff;
   logic [AltW-1:0]  ld_alt_ff;
   logic [ValW-1:0]  ld_q0_ff, ld_q1_ff, ld_q2_ff, ld_q3_ff, ld_q4_ff;
   logic             ld_ok;
   logic [AddrW-1:0] rd_addr;
   logic [AltW-1:0]  rd_alt;
   logic [ValW-1:0]  rd_val;
   logic             div_start, div_done;
   logic [RatioW-1:0] div_ratio;
   logic [AltW:0]    div_num, div_den;
   logic [CntW-1:0]  n_eff;
   logic             accept;

   assign accept = start && !busy;
   assign ld_ok  = (32'(req_row_index) < 32'(TABLE_DEPTH));

   always_comb begin
      if (rows_ff == 12'd0) n_eff = CntW'(1);
      else if (32'(rows_ff) > 32'(TABLE_DEPTH)) n_eff = CntW'(TABLE_DEPTH);
      else n_eff = CntW'(rows_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= 12'd2048;
         load_ff  <= 1'b0;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         rsp_ff   <= rsp_in;
         if (csr_write_enable) rows_ff <= csr_write_data;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      n_ff      <= n_in;
      q_ff      <= q_in;
      alt_i_ff  <= alt_i_in;
      col_ff    <= col_in;
      v1_ff     <= v1_in;
      val_ff    <= val_in;
      diff_ff   <= diff_in;
      ratio_ff  <= ratio_in;
      prod_ff   <= prod_in;
      sel_hi_ff <= sel_hi_in;
      pos_ff    <= pos_in;
      if (accept) begin
         ld_addr_ff <= AddrW'(req_row_index);
         ld_alt_ff  <= req_altitude;
         ld_q0_ff   <= req_density;
         ld_q1_ff   <= req_pressure;
         ld_q2_ff   <= req_temperature;
         ld_q3_ff   <= req_sound_speed;
         ld_q4_ff   <= req_wind_speed;
      end
   end

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   // low then high half of diff times ratio
   assign mul_a = sel_hi_ff ? (RatioW+1)'($signed(diff_ff[ValW:RatioW]))
                            : $signed({1'b0, diff_ff[RatioW-1:0]});
   assign mul_p = mul_a * $signed({1'b0, ratio_ff});

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      n_in      = n_ff;
      q_in      = q_ff;
      alt_i_in  = alt_i_ff;
      col_in    = col_ff;
      v1_in     = v1_ff;
      val_in    = val_ff;
      diff_in   = diff_ff;
      ratio_in  = ratio_ff;
      prod_in   = prod_ff;
      sel_hi_in = sel_hi_ff;
      pos_in    = pos_ff;
      load_in   = 1'b0;
      rsp_in    = 1'b0;
      rd_addr   = AddrW'(mid);
      div_start = 1'b0;
      div_num   = {1'b0, AltW'(q_ff - rd_alt)};
      div_den   = {1'b0, AltW'(alt_i_ff - rd_alt)};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  load_in = ld_ok;
               end else begin
                  lo_in  = '0;
                  hi_in  = n_eff;
                  n_in   = n_eff;
                  q_in   = req_altitude;
                  col_in = (req_quantity_select > COL_WIND_SPEED) ? COL_WIND_SPEED
                                                                  : req_quantity_select;
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) state_in = ST_SRCH_CMP;
            else if (lo_ff == '0) begin
               pos_in = POS_FIRST;
               sel_hi_in = 1'b0;
               state_in = ST_VAL_RD;
            end else if (lo_ff >= n_ff) begin
               pos_in = POS_LAST;
               sel_hi_in = 1'b0;
               state_in = ST_VAL_RD;
            end else begin
               pos_in = POS_INTERP;
               state_in = ST_PRV_RD;
            end
         end
         ST_SRCH_CMP: begin
            if ($signed(rd_alt) < q_ff) lo_in = mid + CntW'(1);
            else begin
               hi_in = mid;
               alt_i_in = rd_alt;
            end
            state_in = ST_SRCH_RD;
         end
         ST_PRV_RD: begin
            rd_addr  = AddrW'(lo_ff - CntW'(1));
            state_in = ST_PRV_WAIT;
         end
         ST_PRV_WAIT: begin
            // num and den are positive by the search
            div_start = 1'b1;
            div_num = 33'($signed(q_ff)) - 33'($signed(rd_alt));
            div_den = 33'($signed(alt_i_ff)) - 33'($signed(rd_alt));
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               ratio_in = div_ratio;
               sel_hi_in = 1'b0;
               state_in = ST_VAL_RD;
            end
         end
         ST_VAL_RD: begin
            if (pos_ff == POS_FIRST) rd_addr = '0;
            else if (pos_ff == POS_LAST) rd_addr = AddrW'(n_ff - CntW'(1));
            else if (sel_hi_ff) rd_addr = AddrW'(lo_ff);
            else rd_addr = AddrW'(lo_ff - CntW'(1));
            state_in = ST_VAL_WAIT;
         end
         ST_VAL_WAIT: begin
            if (pos_ff != POS_INTERP) begin
               val_in = rd_val;
               rsp_in = 1'b1;
               state_in = ST_DONE;
            end else if (!sel_hi_ff) begin
               v1_in = rd_val;
               sel_hi_in = 1'b1;
               state_in = ST_VAL_RD;
            end else begin
               diff_in = $signed({rd_val[ValW-1], rd_val}) - $signed({v1_ff[ValW-1], v1_ff});
               sel_hi_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!sel_hi_ff) begin
               prod_in = (ValW+RatioW+2)'(mul_p);
               sel_hi_in = 1'b1;
            end else begin
               prod_in = prod_ff + ((ValW+RatioW+2)'(mul_p) <<< RatioW);
               state_in = ST_DONE;
            end
            pos_in = POS_INTERP;
         end
         ST_DONE: begin
            if (pos_ff == POS_INTERP && !rsp_ff) begin
               val_in = v1_ff + ValW'(prod_ff >>> 24);
               rsp_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE) || load_ff || rsp_ff;

   itl_tables #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_tables (
      .clock   (clock),
      .wr_en   (load_ff),
      .wr_addr (ld_addr_ff),
      .wr_alt  (ld_alt_ff),
      .wr_q0   (ld_q0_ff),
      .wr_q1   (ld_q1_ff),
      .wr_q2   (ld_q2_ff),
      .wr_q3   (ld_q3_ff),
      .wr_q4   (ld_q4_ff),
      .rd_addr (rd_addr),
      .rd_col  (col_ff),
      .rd_alt  (rd_alt),
      .rd_val  (rd_val)
   );

   itl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .ratio (div_ratio)
   );

   assign rsp_valid    = rsp_ff;
   assign rsp_value    = val_ff;
   assign rsp_position = pos_ff;

`ifndef SYNTHESIS
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ff |=> !rsp_ff) else $error("response held two cycles");
   a_lo_hi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_CMP) |-> (lo_ff < hi_ff && hi_ff <= n_ff))
      else $error("search bounds broken");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_ff |-> busy) else $error("idle while responding");
   a_ratio: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_ratio <= (RatioW'(1) << 24))) else $error("ratio above one");
`endif
endmodule
`default_nettype wire
